@@ src/pmsf_pkg.sv @@
// Shared types, constants and codes of the pulse and motion seizure flagger.
`timescale 1ns / 1ps

package pmsf_pkg;

    // Default ring depths.
    localparam int RATE_DEPTH_DEFAULT      = 4;
    localparam int MAGNITUDE_DEPTH_DEFAULT = 20;

    // Fixed widths of the arithmetic.
    localparam int TIME_W = 32;
    localparam int SQ_W   = 32;
    localparam int ROOT_W = 16;
    localparam int MAG_W  = 16;
    localparam int RATE_W = 8;

    // Largest values that enter the running sums.
    localparam int RATE_MAX = 255;
    localparam int MAG_MAX  = 56756;

    // Beats per minute from a millisecond interval: 60 s times 1000 ms.
    localparam int RATE_NUMERATOR = 60 * 1000;

    // Register reset values.
    localparam logic [17:0] IR_THRESHOLD_RESET = 18'd10000;
    localparam logic [7:0]  RATE_LOW_RESET     = 8'd50;
    localparam logic [7:0]  RATE_HIGH_RESET    = 8'd120;
    localparam logic [15:0] MOTION_RESET       = 16'd25000;
    localparam logic [15:0] SHAKE_RESET        = 16'd30000;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IR_THRESHOLD = 3'd0,
        CFG_RATE_LOW     = 3'd1,
        CFG_RATE_HIGH    = 3'd2,
        CFG_MOTION       = 3'd3,
        CFG_SHAKE        = 3'd4
    } cfg_index_t;

    localparam logic [1:0] COND_NORMAL    = 2'd0;
    localparam logic [1:0] COND_FIT       = 2'd1;
    localparam logic [1:0] COND_SHAKING   = 2'd2;
    localparam logic [1:0] COND_NO_FINGER = 2'd3;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic [17:0] ir_presence_threshold;
        logic [7:0]  rate_low_limit;
        logic [7:0]  rate_high_limit;
        logic [15:0] motion_threshold;
        logic [15:0] shake_threshold;
    } cfg_t;

    typedef struct packed {
        logic [17:0]        ir_level;
        logic               beat_seen;
        logic [31:0]        time_ms;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } in_t;

    typedef struct packed {
        logic        finger_present;
        logic [7:0]  rate_average;
        logic [15:0] motion_magnitude;
        logic [15:0] motion_average;
        logic [1:0]  condition;
        logic        abnormal;
    } out_t;

    typedef struct packed {
        logic  load_in;
        logic  no_finger;
        logic  beat_upd;
        logic  sq_mul;
        axis_t sq_axis;
        logic  acc_load;
        logic  acc_add;
        logic  root_start;
        logic  rate_push;
        logic  ravg_take;
        logic  mag_push;
        logic  mavg_take;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic finger;
        logic beat;
        logic rate_ok;
        logic div_busy;
        logic root_busy;
        logic out_free;
    } status_t;

endpackage

@@ src/pmsf_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module pmsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/pmsf_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pmsf_div #(
    parameter int DW = 21,
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dsr_reg;
    logic [DW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW:0]   trial;
    logic          ge;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            dsr_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
            cnt_reg <= CW'(DW);
        end
        else if (busy)
        begin
            rem_reg <= ge ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

@@ src/pmsf_sqrt.sv @@
// Floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module pmsf_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pmsf_pkg::SQ_W-1:0]   radicand,
    output logic                        busy,
    output logic [pmsf_pkg::ROOT_W-1:0] root
);

    localparam int RW = pmsf_pkg::ROOT_W;
    localparam int SW = pmsf_pkg::SQ_W;
    localparam int CW = $clog2(RW + 1);

    logic [SW-1:0]   rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    // The partial remainder never exceeds twice the partial root, so its low
    // bits are all that survive the two-bit shift.
    assign rem_sh = {rem_reg[RW-1:0], rad_reg[SW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign busy   = cnt_reg != '0;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CW'(RW);
        end
        else if (busy)
        begin
            rad_reg  <= {rad_reg[SW-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[RW-2:0], ge};
            cnt_reg  <= cnt_reg - CW'(1);
        end
    end

endmodule

@@ src/pmsf_dp.sv @@
// Datapath: sample register, rate and magnitude rings, arithmetic units, result register.
`timescale 1ns / 1ps

module pmsf_dp #(
    parameter int RATE_DEPTH      = pmsf_pkg::RATE_DEPTH_DEFAULT,
    parameter int MAGNITUDE_DEPTH = pmsf_pkg::MAGNITUDE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pmsf_pkg::cfg_t    cfg,
    input  pmsf_pkg::in_t     sample,
    input  pmsf_pkg::cmd_t    cmd,
    output pmsf_pkg::status_t status,
    input  logic              result_ready,
    output logic              result_valid,
    output pmsf_pkg::out_t    result
);

    localparam int RSLOT_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
    localparam int MSLOT_W = (MAGNITUDE_DEPTH > 1) ? $clog2(MAGNITUDE_DEPTH) : 1;
    localparam int RSUM_W  = $clog2(pmsf_pkg::RATE_MAX * RATE_DEPTH + 1);
    localparam int MSUM_W  = $clog2(pmsf_pkg::MAG_MAX * MAGNITUDE_DEPTH + 1);
    localparam int NUM_W   = $clog2(pmsf_pkg::RATE_NUMERATOR + 1);
    localparam int DIV_W   = NUM_W;
    localparam int TW      = pmsf_pkg::TIME_W;
    localparam int MW      = pmsf_pkg::MAG_W;
    localparam int RW      = pmsf_pkg::RATE_W;

    // Ring means by reciprocal multiplication. With the shift at the sum width plus the
    // bits of the depth, the rounded-up reciprocal gives the exact floor for every sum.
    localparam int     RSHIFT  = RSUM_W + $clog2(RATE_DEPTH);
    localparam int     MSHIFT  = MSUM_W + $clog2(MAGNITUDE_DEPTH);
    localparam int     RPROD_W = RSUM_W + RSHIFT + 1;
    localparam int     MPROD_W = MSUM_W + MSHIFT + 1;
    localparam longint RRECIP  = ((longint'(1) << RSHIFT) + longint'(RATE_DEPTH) - 1)
                               / longint'(RATE_DEPTH);
    localparam longint MRECIP  = ((longint'(1) << MSHIFT) + longint'(MAGNITUDE_DEPTH) - 1)
                               / longint'(MAGNITUDE_DEPTH);

    pmsf_pkg::in_t  sample_reg;
    pmsf_pkg::out_t result_reg;
    logic           result_valid_reg;

    logic [TW-1:0]      last_beat_reg;
    logic               rate_pend_reg;
    logic [31:0]        prod_reg;
    logic [31:0]        acc_reg;
    logic [RW-1:0]      rate_ring_reg [RATE_DEPTH];
    logic [RSLOT_W-1:0] rate_slot_reg;
    logic [RSUM_W-1:0]  rate_sum_reg;
    logic [RW-1:0]      held_avg_reg;
    logic [MSLOT_W-1:0] mag_slot_reg;
    logic               mag_full_reg;
    logic [MSUM_W-1:0]  mag_sum_reg;
    logic [MW-1:0]      mag_reg;
    logic [MW-1:0]      mavg_reg;

    logic [TW-1:0]      interval;
    logic [15:0]        axis_val;
    logic [15:0]        axis_abs;
    logic [31:0]        radicand;
    logic               root_busy;
    logic [MW-1:0]      root;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [TW-1:0]      div_divisor;
    logic               div_busy;
    logic [DIV_W-1:0]   div_quo;
    logic [RSUM_W-1:0]  rate_sum_next;
    logic [MW-1:0]      ram_rdata;
    logic [MW-1:0]      mag_old;
    logic [MSUM_W-1:0]  mag_sum_next;
    logic [RPROD_W-1:0] rate_prod;
    logic [MPROD_W-1:0] mag_prod;
    logic               finger;
    logic               rate_bad;
    logic               high_motion;
    logic               extreme;
    logic [1:0]         cond;

    assign interval = sample_reg.time_ms - last_beat_reg;
    assign finger   = sample_reg.ir_level >= cfg.ir_presence_threshold;

    always_comb
    begin
        case (cmd.sq_axis)
            pmsf_pkg::AXIS_X: axis_val = sample_reg.accel_x;
            pmsf_pkg::AXIS_Y: axis_val = sample_reg.accel_y;
            pmsf_pkg::AXIS_Z: axis_val = sample_reg.accel_z;
            default:          axis_val = '0;
        endcase
    end

    // Magnitude of a two's complement axis; the most negative value maps to 2^15.
    assign axis_abs = axis_val[15] ? (~axis_val + 16'd1) : axis_val;
    assign radicand = acc_reg + prod_reg;

    pmsf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (radicand),
        .busy     (root_busy),
        .root     (root)
    );

    assign rate_sum_next = rate_sum_reg - RSUM_W'(rate_ring_reg[rate_slot_reg])
                         + RSUM_W'(div_quo[RW-1:0]);

    assign mag_old      = mag_full_reg ? ram_rdata : '0;
    assign mag_sum_next = mag_sum_reg - MSUM_W'(mag_old) + MSUM_W'(root);

    assign rate_prod = RPROD_W'(rate_sum_reg) * RPROD_W'(RRECIP);
    assign mag_prod  = MPROD_W'(mag_sum_reg) * MPROD_W'(MRECIP);

    // The divider only forms the beat rate from the interval.
    assign div_start    = cmd.beat_upd && interval != '0;
    assign div_dividend = DIV_W'(pmsf_pkg::RATE_NUMERATOR);
    assign div_divisor  = interval;

    pmsf_div #(
        .DW (DIV_W),
        .VW (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    pmsf_ram #(
        .WIDTH (MW),
        .DEPTH (MAGNITUDE_DEPTH)
    ) u_mag_ram (
        .clk   (clk),
        .we    (cmd.mag_push),
        .waddr (mag_slot_reg),
        .wdata (root),
        .raddr (mag_slot_reg),
        .rdata (ram_rdata)
    );

    assign rate_bad    = held_avg_reg > cfg.rate_high_limit
                      || held_avg_reg < cfg.rate_low_limit;
    assign high_motion = mavg_reg > cfg.motion_threshold;
    assign extreme     = mag_reg > cfg.shake_threshold;

    always_comb
    begin
        if (rate_bad && high_motion)
        begin
            cond = pmsf_pkg::COND_FIT;
        end
        else if (high_motion && extreme)
        begin
            cond = pmsf_pkg::COND_SHAKING;
        end
        else
        begin
            cond = pmsf_pkg::COND_NORMAL;
        end
    end

    assign status.finger    = finger;
    assign status.beat      = sample_reg.beat_seen;
    assign status.rate_ok   = rate_pend_reg
                           && div_quo > DIV_W'(cfg.rate_low_limit)
                           && div_quo < DIV_W'(cfg.rate_high_limit);
    assign status.div_busy  = div_busy;
    assign status.root_busy = root_busy;
    assign status.out_free  = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg       <= '0;
            last_beat_reg    <= '0;
            rate_pend_reg    <= 1'b0;
            prod_reg         <= '0;
            acc_reg          <= '0;
            for (int j = 0; j < RATE_DEPTH; j++)
            begin
                rate_ring_reg[j] <= '0;
            end
            rate_slot_reg    <= '0;
            rate_sum_reg     <= '0;
            held_avg_reg     <= '0;
            mag_slot_reg     <= '0;
            mag_full_reg     <= 1'b0;
            mag_sum_reg      <= '0;
            mag_reg          <= '0;
            mavg_reg         <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                sample_reg    <= sample;
                rate_pend_reg <= 1'b0;
            end
            if (cmd.no_finger)
            begin
                held_avg_reg <= '0;
            end
            if (cmd.beat_upd)
            begin
                last_beat_reg <= sample_reg.time_ms;
                rate_pend_reg <= interval != '0;
            end
            if (cmd.sq_mul)
            begin
                prod_reg <= 32'(axis_abs) * 32'(axis_abs);
            end
            if (cmd.acc_load)
            begin
                acc_reg <= prod_reg;
            end
            else if (cmd.acc_add)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
            if (cmd.rate_push)
            begin
                rate_ring_reg[rate_slot_reg] <= div_quo[RW-1:0];
                rate_sum_reg                 <= rate_sum_next;
                rate_slot_reg <= (rate_slot_reg == RSLOT_W'(RATE_DEPTH - 1))
                               ? '0 : rate_slot_reg + RSLOT_W'(1);
            end
            if (cmd.ravg_take)
            begin
                held_avg_reg <= rate_prod[RSHIFT +: RW];
            end
            if (cmd.mag_push)
            begin
                mag_reg     <= root;
                mag_sum_reg <= mag_sum_next;
                if (mag_slot_reg == MSLOT_W'(MAGNITUDE_DEPTH - 1))
                begin
                    mag_slot_reg <= '0;
                    mag_full_reg <= 1'b1;
                end
                else
                begin
                    mag_slot_reg <= mag_slot_reg + MSLOT_W'(1);
                end
            end
            if (cmd.mavg_take)
            begin
                mavg_reg <= mag_prod[MSHIFT +: MW];
            end
            if (cmd.out_load)
            begin
                result_valid_reg <= 1'b1;
                if (finger)
                begin
                    result_reg.finger_present   <= 1'b1;
                    result_reg.rate_average     <= held_avg_reg;
                    result_reg.motion_magnitude <= mag_reg;
                    result_reg.motion_average   <= mavg_reg;
                    result_reg.condition        <= cond;
                    result_reg.abnormal         <= cond != pmsf_pkg::COND_NORMAL;
                end
                else
                begin
                    result_reg.finger_present   <= 1'b0;
                    result_reg.rate_average     <= '0;
                    result_reg.motion_magnitude <= '0;
                    result_reg.motion_average   <= '0;
                    result_reg.condition        <= pmsf_pkg::COND_NO_FINGER;
                    result_reg.abnormal         <= 1'b0;
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ src/pmsf_ctrl.sv @@
// Controller: sequences one sample through the datapath.
`timescale 1ns / 1ps

module pmsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  pmsf_pkg::status_t status,
    output pmsf_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQY,
        S_SQZ,
        S_SQSUM,
        S_ROOT,
        S_RATE,
        S_RAVG,
        S_MAG,
        S_MDIV,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign sample_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.sq_axis = pmsf_pkg::AXIS_X;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.finger)
                begin
                    cmd.no_finger = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.beat_upd = status.beat;
                    cmd.sq_mul   = 1'b1;
                    cmd.sq_axis  = pmsf_pkg::AXIS_X;
                    state_next   = S_SQY;
                end
            end
            S_SQY:
            begin
                cmd.sq_mul   = 1'b1;
                cmd.sq_axis  = pmsf_pkg::AXIS_Y;
                cmd.acc_load = 1'b1;
                state_next   = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.sq_mul  = 1'b1;
                cmd.sq_axis = pmsf_pkg::AXIS_Z;
                cmd.acc_add = 1'b1;
                state_next  = S_SQSUM;
            end
            S_SQSUM:
            begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                if (!status.root_busy && !status.div_busy)
                begin
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                if (status.rate_ok)
                begin
                    cmd.rate_push = 1'b1;
                    state_next    = S_RAVG;
                end
                else
                begin
                    state_next = S_MAG;
                end
            end
            S_RAVG:
            begin
                cmd.ravg_take = 1'b1;
                state_next    = S_MAG;
            end
            S_MAG:
            begin
                cmd.mag_push = 1'b1;
                state_next   = S_MDIV;
            end
            S_MDIV:
            begin
                cmd.mavg_take = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/pulse_motion_seizure_flagger_top.sv @@
// Top level of the pulse and motion seizure flagger.
`timescale 1ns / 1ps

// Usage.
// The sample channel (sample_valid, sample_ready, sample) takes one sensor item:
// IR level, beat flag, millisecond time stamp and three accelerometer axes.
// The result channel (result_valid, result_ready, result) returns exactly one
// item per sample, in order. The configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) writes the five threshold registers; it is always ready
// and is meant to be used only while the block is idle.
// An item with no finger goes from the presence check straight to the result, and the
// next item can be taken once that result is loaded. Otherwise the three axis squares are
// formed in turn, then a two-bit-per-cycle square root runs while, on a beat, a radix-2
// divider forms the beat rate. The ring means come from reciprocal multiplications. A
// beat that gives an accepted rate adds a step that takes the new rate mean.
// One item is worked on at a time; sample_ready rises again once the result is in
// the output register. The result register sits between the two sides, so the next
// sample is accepted while a result still waits; a stalled receiver only holds the
// block once a second result is ready to be loaded.
// Reset clears all registers, the rate ring and both sums, and loads the default
// thresholds. The magnitude ring is a RAM with no clearing pass: a fill flag
// makes entries read as zero until the ring has wrapped once.
module pulse_motion_seizure_flagger_top #(
    parameter int RATE_DEPTH      = pmsf_pkg::RATE_DEPTH_DEFAULT,
    parameter int MAGNITUDE_DEPTH = pmsf_pkg::MAGNITUDE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  pmsf_pkg::in_t                    sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output pmsf_pkg::out_t                   result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pmsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pmsf_pkg::cfg_t    cfg_reg;
    pmsf_pkg::cmd_t    cmd;
    pmsf_pkg::status_t status;

    // Configuration writes are always taken; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ir_presence_threshold <= pmsf_pkg::IR_THRESHOLD_RESET;
            cfg_reg.rate_low_limit        <= pmsf_pkg::RATE_LOW_RESET;
            cfg_reg.rate_high_limit       <= pmsf_pkg::RATE_HIGH_RESET;
            cfg_reg.motion_threshold      <= pmsf_pkg::MOTION_RESET;
            cfg_reg.shake_threshold       <= pmsf_pkg::SHAKE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pmsf_pkg::CFG_IR_THRESHOLD: cfg_reg.ir_presence_threshold <= cfg_data;
                pmsf_pkg::CFG_RATE_LOW:     cfg_reg.rate_low_limit   <= cfg_data[7:0];
                pmsf_pkg::CFG_RATE_HIGH:    cfg_reg.rate_high_limit  <= cfg_data[7:0];
                pmsf_pkg::CFG_MOTION:       cfg_reg.motion_threshold <= cfg_data[15:0];
                pmsf_pkg::CFG_SHAKE:        cfg_reg.shake_threshold  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // The controller owns the sequence; the datapath owns every value.
    pmsf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    pmsf_dp #(
        .RATE_DEPTH      (RATE_DEPTH),
        .MAGNITUDE_DEPTH (MAGNITUDE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    // Once an item is taken, the block is busy with it in the cycle after.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("sample_ready stayed high after an item was accepted");

    a_abnormal_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.abnormal == (result.condition == pmsf_pkg::COND_FIT
                                           || result.condition == pmsf_pkg::COND_SHAKING)))
        else $error("abnormal flag disagrees with condition");

    a_no_finger_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.finger_present)
            |-> (result.condition == pmsf_pkg::COND_NO_FINGER
                 && result.rate_average == '0 && result.motion_average == '0))
        else $error("no-finger result carries data");

    a_finger_condition: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.finger_present)
            |-> (result.condition != pmsf_pkg::COND_NO_FINGER))
        else $error("finger present but condition says no finger");
`endif

endmodule

@@ tb/pulse_motion_seizure_flagger_top_tb.sv @@
// Self-checking testbench for the pulse and motion seizure flagger top level.
`timescale 1ns / 1ps

// The bench drives sensor items into the sample channel and collects one result item per
// sample from the result channel. A behavioral predictor keeps its own copy of the threshold
// registers, the rate ring and the magnitude ring. It works out every expected result when
// the sample item is accepted. Results are checked in order, field by field.
//
// The run has several phases. It starts with a short table of directed items under the
// reset thresholds. Random items follow, and then more random items under several other
// threshold settings, the extremes among them. Thresholds are rewritten only after every
// expected result has come back and the block has had time to go idle.
//
// Inputs change on the falling clock edge. Handshakes and outputs are sampled on the rising
// edge. Sender and receiver each draw a random wait before every item. At times the wait is
// suppressed for a stretch, so that back-to-back traffic is covered too. Once during the run
// the receiver holds off for a long time while samples keep coming. This fills the result
// register and stalls the sample channel.
module pulse_motion_seizure_flagger_top_tb;

    import pmsf_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 10;
    localparam int RANDOM_PER_PHASE = 165;
    localparam int PHASE_COUNT      = 5;
    localparam int DRAIN_CYCLES     = 100;
    localparam int HOLD_AT          = 150;
    localparam int LONG_HOLD        = 400;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int REPORT_LIMIT     = 10;

    localparam int PULSE_DEPTH  = RATE_DEPTH_DEFAULT;
    localparam int MOTION_DEPTH = MAGNITUDE_DEPTH_DEFAULT;

    // This is the result of any item whose IR level is below the presence threshold.
    localparam out_t NO_FINGER_OUT = '{1'b0, 8'd0, 16'd0, 16'd0, COND_NO_FINGER, 1'b0};
    // This is a finger at rest right after reset. The rate mean is still zero, but low motion
    // keeps the result normal.
    localparam out_t RESTING_OUT   = '{1'b1, 8'd0, 16'd0, 16'd0, COND_NORMAL, 1'b0};

    typedef enum int {MODE_CALM, MODE_STRONG, MODE_NOISE, MODE_DROPOUT} motion_mode_t;

    typedef struct {
        in_t  stim;
        bit   typed;
        out_t want;
    } step_row_t;

    typedef struct {
        bit   typed;
        out_t want;
    } answer_t;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_ready;
    in_t  sample;
    logic result_valid;
    logic result_ready;
    out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state. It mirrors the registers and rings of the block.
    cfg_t        thresholds;
    logic [7:0]  pulse_ring [PULSE_DEPTH];
    int          pulse_slot;
    logic [31:0] last_beat_ms;
    logic [7:0]  pulse_mean;
    logic [15:0] motion_ring [MOTION_DEPTH];
    int          motion_slot;
    logic [20:0] motion_total;

    // Results still owed by the block, in the order of their sample items. A directed row
    // with a typed answer travels alongside its item in typed_answers.
    out_t    owed_results [$];
    answer_t typed_answers [$];

    int          mismatches;
    int          sender_calm;
    int          receiver_calm;
    logic [31:0] gen_beat_clock;

    pulse_motion_seizure_flagger_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // This function runs one sensor sample through the predictor, updates its state and
    // returns the result that the block must give.
    function automatic out_t flag_sample(input in_t s);
        out_t        r;
        logic [31:0] gap_ms;
        logic [31:0] bpm;
        int          bpm_total;
        int          b;
        longint      ax;
        longint      ay;
        longint      az;
        logic [63:0] energy;
        logic [63:0] root;
        logic [63:0] trial;
        logic [15:0] mag;
        logic [15:0] mean_mag;
        logic        rate_off;
        logic        busy_motion;
        logic        violent;

        r = '0;
        // With no finger, only the held rate mean is lost, and any beat flag is ignored.
        if (s.ir_level < thresholds.ir_presence_threshold)
        begin
            pulse_mean = 8'd0;
            r.condition = COND_NO_FINGER;
            return r;
        end

        if (s.beat_seen)
        begin
            gap_ms = s.time_ms - last_beat_ms;
            last_beat_ms = s.time_ms;
            // A zero interval gives no rate at all.
            if (gap_ms != 0)
            begin
                bpm = 32'd60000 / gap_ms;
                // Rates must lie strictly inside the limits. Rates equal to a limit are dropped.
                if (bpm > {24'd0, thresholds.rate_low_limit} &&
                    bpm < {24'd0, thresholds.rate_high_limit})
                begin
                    pulse_ring[pulse_slot] = bpm[7:0];
                    pulse_slot = (pulse_slot + 1) % PULSE_DEPTH;
                    bpm_total = 0;
                    for (b = 0; b < PULSE_DEPTH; b++)
                    begin
                        bpm_total += pulse_ring[b];
                    end
                    pulse_mean = 8'(bpm_total / PULSE_DEPTH);
                end
            end
        end

        ax = longint'($signed(s.accel_x));
        ay = longint'($signed(s.accel_y));
        az = longint'($signed(s.accel_z));
        energy = 64'(ax * ax + ay * ay + az * az);

        // This is a floor square root, built one bit at a time from the top down.
        root = '0;
        for (b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= energy)
            begin
                root = trial;
            end
        end
        mag = root[15:0];

        motion_total = motion_total - 21'(motion_ring[motion_slot]) + 21'(mag);
        motion_ring[motion_slot] = mag;
        motion_slot = (motion_slot + 1) % MOTION_DEPTH;
        mean_mag = 16'(motion_total / MOTION_DEPTH);

        rate_off    = pulse_mean > thresholds.rate_high_limit ||
                      pulse_mean < thresholds.rate_low_limit;
        busy_motion = mean_mag > thresholds.motion_threshold;
        violent     = mag > thresholds.shake_threshold;

        r.finger_present   = 1'b1;
        r.rate_average     = pulse_mean;
        r.motion_magnitude = mag;
        r.motion_average   = mean_mag;
        if (rate_off && busy_motion)
        begin
            r.condition = COND_FIT;
        end
        else if (busy_motion && violent)
        begin
            r.condition = COND_SHAKING;
        end
        else
        begin
            r.condition = COND_NORMAL;
        end
        r.abnormal = (r.condition != COND_NORMAL);
        return r;
    endfunction

    // This returns a random wait in cycles. Now and then it starts a stretch of waits of zero.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // This returns one accelerometer axis value that matches the current motion episode.
    function automatic logic [15:0] axis_value(input motion_mode_t mode);
        int v;

        case (mode)
            MODE_STRONG:
            begin
                v = $urandom_range(12000, 32767);
                if ($urandom_range(0, 7) == 0)
                begin
                    v = 32767;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v - 1;
                end
            end
            MODE_NOISE:
            begin
                v = $urandom();
            end
            default:
            begin
                v = int'($urandom_range(0, 8000)) - 4000;
            end
        endcase
        return 16'(v);
    endfunction

    function automatic in_t sample_of(input int ir, input bit beat, input logic [31:0] t,
                                      input int x, input int y, input int z);
        in_t r;

        r.ir_level  = 18'(ir);
        r.beat_seen = beat;
        r.time_ms   = t;
        r.accel_x   = 16'(x);
        r.accel_y   = 16'(y);
        r.accel_z   = 16'(z);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
            end
        end
    endtask

    // The scoreboard works on the rising edge. It applies register writes, predicts each
    // accepted sample item and checks each accepted result item. Reset brings the predictor
    // back to the state of a freshly reset block.
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        answer_t ans;
        out_t    want;
        out_t    guess;
        int      k;

        if (!rst_n)
        begin
            thresholds   = '{IR_THRESHOLD_RESET, RATE_LOW_RESET, RATE_HIGH_RESET,
                             MOTION_RESET, SHAKE_RESET};
            pulse_slot   = 0;
            last_beat_ms = '0;
            pulse_mean   = '0;
            motion_slot  = 0;
            motion_total = '0;
            for (k = 0; k < PULSE_DEPTH; k++)
            begin
                pulse_ring[k] = '0;
            end
            for (k = 0; k < MOTION_DEPTH; k++)
            begin
                motion_ring[k] = '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_IR_THRESHOLD: thresholds.ir_presence_threshold = cfg_data[17:0];
                    CFG_RATE_LOW:     thresholds.rate_low_limit        = cfg_data[7:0];
                    CFG_RATE_HIGH:    thresholds.rate_high_limit       = cfg_data[7:0];
                    CFG_MOTION:       thresholds.motion_threshold      = cfg_data[15:0];
                    CFG_SHAKE:        thresholds.shake_threshold       = cfg_data[15:0];
                    default:          ;
                endcase
            end

            if (sample_valid && sample_ready)
            begin
                // The predictor always runs, so that its state keeps step even on rows whose
                // answer was typed into the directed table.
                guess = flag_sample(sample);
                ans = typed_answers.pop_front();
                owed_results.push_back(ans.typed ? ans.want : guess);
            end

            if (result_valid && result_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: result item with none expected: %p", $realtime, result);
                    end
                end
                else
                begin
                    want = owed_results.pop_front();
                    compare_field("finger_present", 16'(want.finger_present),
                                  16'(result.finger_present));
                    compare_field("rate_average", 16'(want.rate_average),
                                  16'(result.rate_average));
                    compare_field("motion_magnitude", want.motion_magnitude,
                                  result.motion_magnitude);
                    compare_field("motion_average", want.motion_average,
                                  result.motion_average);
                    compare_field("condition", 16'(want.condition), 16'(result.condition));
                    compare_field("abnormal", 16'(want.abnormal), 16'(result.abnormal));
                end
            end
        end
    end

    // The receiver draws a stall before every result item. Once, after a fixed number of
    // result items, it holds off for a long stretch. In that time the sender keeps offering
    // samples and the block backs up.
    initial
    begin : receiver
        int stall;
        int taken;

        result_ready = 1'b0;
        taken = 0;
        receiver_calm = 0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(receiver_calm);
            if (taken == HOLD_AT)
            begin
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            taken++;
        end
    end

    // Offer one sample item after a random gap and hold it until it is accepted. The valid
    // line stays high from one item to the next when the gap is zero.
    task automatic send_sample(input in_t s, input bit typed, input out_t want);
        int gap;

        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        typed_answers.push_back('{typed, want});
        sample <= s;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
    endtask

    // Stop offering samples, wait for every owed result, then give the block time to go idle.
    task automatic settle_block();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_thresholds(input cfg_t c);
        write_register(CFG_IR_THRESHOLD, c.ir_presence_threshold);
        write_register(CFG_RATE_LOW, 18'(c.rate_low_limit));
        write_register(CFG_RATE_HIGH, 18'(c.rate_high_limit));
        write_register(CFG_MOTION, 18'(c.motion_threshold));
        write_register(CFG_SHAKE, 18'(c.shake_threshold));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random items come in episodes: calm wear, strong motion, raw noise, and short finger
    // dropouts. Long strong episodes are needed to lift the motion average over its threshold.
    // Dropouts clear the rate mean, which is what turns strong motion into a possible fit.
    // Beats mostly arrive at plausible heart rate intervals. A few have tiny, zero or wild
    // intervals.
    task automatic run_random(input int count);
        int           n;
        int           left;
        int           pick;
        motion_mode_t mode;
        in_t          s;
        logic [17:0]  floor_ir;

        mode = MODE_CALM;
        left = 0;
        for (n = 0; n < count; n++)
        begin
            if (left == 0)
            begin
                mode = motion_mode_t'($urandom_range(0, 3));
                left = (mode == MODE_DROPOUT) ? $urandom_range(1, 4) : $urandom_range(4, 40);
            end
            left--;
            floor_ir = thresholds.ir_presence_threshold;

            if (mode == MODE_DROPOUT && floor_ir != 0)
            begin
                s.ir_level = 18'($urandom_range(0, floor_ir - 1));
            end
            else if ($urandom_range(0, 31) == 0)
            begin
                s.ir_level = 18'($urandom());
            end
            else
            begin
                s.ir_level = 18'($urandom_range(floor_ir, 18'h3FFFF));
            end

            s.beat_seen = (mode == MODE_DROPOUT) ? ($urandom_range(0, 1) == 1)
                                                 : ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (!s.beat_seen)
            begin
                s.time_ms = (mode == MODE_NOISE) ? $urandom()
                                                 : gen_beat_clock + $urandom_range(0, 3000);
            end
            else if (pick < 7)
            begin
                s.time_ms = gen_beat_clock + $urandom_range(300, 1500);
            end
            else if (pick == 7)
            begin
                s.time_ms = gen_beat_clock + $urandom_range(1, 299);
            end
            else if (pick == 8)
            begin
                s.time_ms = gen_beat_clock;
            end
            else
            begin
                s.time_ms = $urandom();
            end

            s.accel_x = axis_value(mode);
            s.accel_y = axis_value(mode);
            s.accel_z = axis_value(mode);

            // Follow the block's idea of the last beat, so that intervals stay meaningful.
            if (s.ir_level >= floor_ir && s.beat_seen)
            begin
                gen_beat_clock = s.time_ms;
            end
            send_sample(s, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        step_row_t directed_steps [$];
        cfg_t      phase_cfg [PHASE_COUNT];
        int        p;

        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        sender_calm  = 0;
        gen_beat_clock = '0;

        // Directed rows run under the reset thresholds. Rows with a typed answer are the
        // obvious ones. All the others rely on the predictor.
        // A sample below the presence threshold ignores its beat. This one has the most
        // negative axes and the largest time stamp.
        directed_steps.push_back('{sample_of(0, 1'b1, 32'hFFFF_FFFF, -32768, -32768, -32768),
                                   1'b1, NO_FINGER_OUT});
        directed_steps.push_back('{sample_of(9999, 1'b0, 32'd0, 32767, 32767, 32767),
                                   1'b1, NO_FINGER_OUT});
        // An IR level exactly at the threshold counts as a finger.
        directed_steps.push_back('{sample_of(10000, 1'b0, 32'd0, 0, 0, 0), 1'b1, RESTING_OUT});
        // The largest IR level, and a first beat 1000 ms after time zero: 60 per minute.
        directed_steps.push_back('{sample_of(262143, 1'b1, 32'd1000, 0, 0, 0), 1'b0, '0});
        // A beat at the same time stamp is a zero interval, so no rate is formed.
        directed_steps.push_back('{sample_of(20000, 1'b1, 32'd1000, 100, -200, 300), 1'b0, '0});
        directed_steps.push_back('{sample_of(20000, 1'b1, 32'd1750, -5, 7, 9), 1'b0, '0});
        // Rates equal to the upper or the lower limit are rejected.
        directed_steps.push_back('{sample_of(20000, 1'b1, 32'd2250, 0, 0, 1), 1'b0, '0});
        directed_steps.push_back('{sample_of(20000, 1'b1, 32'd3450, 3, 4, 0), 1'b0, '0});
        // This rate is just above the lower limit and is accepted.
        directed_steps.push_back('{sample_of(20000, 1'b1, 32'd4626, 1000, 0, 0), 1'b0, '0});
        // A huge interval floors to a rate of zero. The next beat wraps the time stamp.
        directed_steps.push_back('{sample_of(20000, 1'b1, 32'hFFFF_FF00, 0, -1000, 0),
                                   1'b0, '0});
        directed_steps.push_back('{sample_of(20000, 1'b1, 32'h0000_0100, 0, 0, 2000),
                                   1'b0, '0});
        // Extreme axes push the magnitude to its top and lift the average until it reads
        // as shaking.
        repeat (5)
        begin
            directed_steps.push_back('{sample_of(20000, 1'b0, 32'd0, -32768, -32768, -32768),
                                       1'b0, '0});
        end
        repeat (4)
        begin
            directed_steps.push_back('{sample_of(20000, 1'b0, 32'd0, 32767, 32767, 32767),
                                       1'b0, '0});
        end
        // A finger dropout clears the rate mean. Strong motion right after it reads as a
        // possible fit, and the next accepted beat restores the mean.
        directed_steps.push_back('{sample_of(5000, 1'b1, 32'd5000, 1, 2, 3), 1'b1, NO_FINGER_OUT});
        directed_steps.push_back('{sample_of(20000, 1'b0, 32'd0, -32768, -32768, -32768),
                                   1'b0, '0});
        directed_steps.push_back('{sample_of(20000, 1'b1, 32'd856, 32767, 32767, 32767),
                                   1'b0, '0});
        directed_steps.push_back('{sample_of(20000, 1'b0, 32'd0, 1, -1, 0), 1'b0, '0});
        directed_steps.push_back('{sample_of(20000, 1'b0, 32'd0, 32767, -32768, 0), 1'b0, '0});

        // Threshold settings for the later phases: presence and motion thresholds at their floor
        // with the widest rate limits, everything at its ceiling with inverted rate limits, limits
        // one apart, a moderate setting, and the reset values again.
        phase_cfg[0] = '{18'd0, 8'd1, 8'd255, 16'd0, 16'd0};
        phase_cfg[1] = '{18'd262143, 8'd255, 8'd1, 16'd56756, 16'd56756};
        phase_cfg[2] = '{18'd5000, 8'd99, 8'd100, 16'd8000, 16'd15000};
        phase_cfg[3] = '{18'd30000, 8'd60, 8'd100, 16'd12000, 16'd40000};
        phase_cfg[4] = '{IR_THRESHOLD_RESET, RATE_LOW_RESET, RATE_HIGH_RESET,
                         MOTION_RESET, SHAKE_RESET};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            send_sample(directed_steps[i].stim, directed_steps[i].typed, directed_steps[i].want);
        end
        run_random(RANDOM_PER_PHASE);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            settle_block();
            load_thresholds(phase_cfg[p]);
            run_random(RANDOM_PER_PHASE);
        end

        settle_block();
        if (mismatches == 0 && owed_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // This is a hard limit on the run length, far beyond the slowest correct run.
    initial
    begin : watchdog
        int cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
